>>> design/pwm_fractional_duty_dither_unit_assert.svh
// Assertion macros for the PWM duty dither unit.
// Taken in by the checker file; needs nothing else.
`ifndef PWM_FRACTIONAL_DUTY_DITHER_UNIT_ASSERT_SVH
`define PWM_FRACTIONAL_DUTY_DITHER_UNIT_ASSERT_SVH

// Check a property only while out of reset.
`define PFDD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define PFDD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/pfdd_pkg.sv
// Shared types and constants for the PWM duty dither unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pfdd_pkg;

  localparam int CHANNELS     = 16;
  localparam int CH_W         = 4;
  localparam int DEV_W        = 7;
  localparam int REG_W        = 7;
  localparam int COUNT_W      = 12;
  localparam int LOAD_W       = 14;
  localparam int EXACT_W      = 16;
  localparam int CTR_W        = 3;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 32;

  localparam logic [COUNT_W-1:0] MAX_COUNT    = 12'd4095;
  localparam logic [REG_W-1:0]   FIRST_REG    = 7'h06;
  localparam logic [CTR_W:0]     COUNTER_WRAP = 4'd4;
  localparam logic [DEV_W-1:0]   DEV_RESET    = 7'd64;

  typedef enum logic [1:0] {
    OP_SET_LOAD  = 2'd0,
    OP_SET_EXACT = 2'd1,
    OP_UPDATE    = 2'd2
  } op_t;

  // One channel's stored record
  typedef struct packed {
    logic [LOAD_W-1:0]  duty;
    logic [EXACT_W-1:0] last;
    logic [CTR_W-1:0]   ctr;
  } chan_rec_t;

  // Outcome of one item
  typedef struct packed {
    logic               emit;
    logic               wr;
    chan_rec_t          rec;
    logic [COUNT_W-1:0] off_count;
  } upd_res_t;

endpackage

>>> design/pwm_fractional_duty_dither_unit.sv
// PWM fractional duty dither unit, top level.
// Path from input beat to result beat: record read (registered), then modify/write-back into the output register.
// A new item is taken only once the current item's write-back completes.
// Reset (synchronous, rst_n low): device address to 64, all channel records read as zero.
// A waiting result beat stalls the next item's write-back only when that item emits.
`timescale 1ns / 1ps

module pwm_fractional_duty_dither_unit
  import pfdd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // operation[1:0], channel[6:2], scaled_load[20:7], exact_count[36:21], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // bus_device[6:0], reg_address[13:7], off_count[25:14], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [DEV_W-1:0]      cfg_wdata
);

  logic [DEV_W-1:0]    dev_addr_r;
  logic                busy_r;
  logic                drop_r;
  logic [1:0]          op_r;
  logic [CH_W-1:0]     ch_r;
  logic [LOAD_W-1:0]   load_r;
  logic [EXACT_W-1:0]  exact_r;
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                in_fire;
  logic [4:0]          in_ch;
  logic                done;
  logic                slot_free;
  chan_rec_t           rd_rec;
  upd_res_t            res;
  logic [REG_W-1:0]    reg_addr;

  assign in_tready = !busy_r;
  assign in_fire   = in_tvalid && in_tready;
  assign in_ch     = in_tdata[6:2];
  assign slot_free = !out_valid_r || out_tready;
  assign done      = busy_r && (!res.emit || slot_free);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_RESET;
    end else if (cfg_we) begin
      dev_addr_r <= cfg_wdata;
    end
  end

  // Item in flight: hold until its write-back completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_fire) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  // Capture the item; an unused operation falls to the modify step's default arm
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_tdata[1:0];
      ch_r    <= in_ch[CH_W-1:0];
      drop_r  <= ({27'd0, in_ch} >= CHANNELS);
      load_r  <= in_tdata[20:7];
      exact_r <= in_tdata[36:21];
    end
  end

  pfdd_chan_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (in_ch[CH_W-1:0]),
    .wr_en   (done && res.wr),
    .wr_addr (ch_r),
    .wr_data (res.rec),
    .rd_data (rd_rec)
  );

  pfdd_update u_upd (
    .drop        (drop_r),
    .op          (op_r),
    .scaled_load (load_r),
    .exact_count (exact_r),
    .rec         (rd_rec),
    .res         (res)
  );

  assign reg_addr = FIRST_REG + {1'b0, ch_r, 2'b00};

  // Output register: load on an emitting item, drop on take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && res.emit) begin
      out_data_r <= {6'd0, res.off_count, reg_addr, dev_addr_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> design/pfdd_chan_ram.sv
// Channel record memory: one read and one write port, registered read data.
// Entries never written since reset read as zero. Depends on pfdd_pkg.
`timescale 1ns / 1ps

module pfdd_chan_ram
  import pfdd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  logic [CH_W-1:0] rd_addr,
  input  logic            wr_en,
  input  logic [CH_W-1:0] wr_addr,
  input  chan_rec_t       wr_data,
  output chan_rec_t       rd_data
);

  chan_rec_t             mem [CHANNELS];
  logic [CHANNELS-1:0]   vld_r;
  chan_rec_t             rd_data_r;
  logic                  rd_vld_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Track written entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Read port, registered; hold data between reads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (rd_en) begin
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

>>> design/pfdd_update.sv
// Per-item modify step: new record, write-back and result count.
// Depends on pfdd_pkg.
`timescale 1ns / 1ps

module pfdd_update
  import pfdd_pkg::*;
(
  input  logic               drop,
  input  logic [1:0]         op,
  input  logic [LOAD_W-1:0]  scaled_load,
  input  logic [EXACT_W-1:0] exact_count,
  input  chan_rec_t          rec,
  output upd_res_t           res
);

  logic [CTR_W:0]     cnt;
  logic [CTR_W:0]     cnt_wrap;
  logic [1:0]         frac;
  logic [COUNT_W:0]   target;

  // Dither target for an update
  always_comb begin
    cnt      = {1'b0, rec.ctr} + 1'b1;
    cnt_wrap = (cnt > COUNTER_WRAP) ? '0 : cnt;
    frac     = rec.duty[1:0];
    target   = {1'b0, rec.duty[LOAD_W-1:2]} + {{COUNT_W{1'b0}}, (cnt_wrap < {2'b00, frac})};
  end

  // Select the action for the operation
  always_comb begin
    res           = '0;
    res.rec       = rec;
    if (!drop) begin
      case (op_t'(op))
        OP_SET_LOAD: begin
          res.emit      = 1'b1;
          res.wr        = 1'b1;
          res.rec.duty  = scaled_load;
          res.rec.last  = {{(EXACT_W-COUNT_W){1'b0}}, scaled_load[LOAD_W-1:2]};
          res.off_count = scaled_load[LOAD_W-1:2];
        end
        OP_SET_EXACT: begin
          res.emit      = 1'b1;
          res.wr        = 1'b1;
          res.rec.last  = exact_count;
          res.off_count = (exact_count > {4'd0, MAX_COUNT}) ? MAX_COUNT
                                                          : exact_count[COUNT_W-1:0];
        end
        OP_UPDATE: begin
          res.wr        = 1'b1;
          res.rec.ctr   = cnt_wrap[CTR_W-1:0];
          res.emit      = (rec.last != {{(EXACT_W-COUNT_W-1){1'b0}}, target});
          if (res.emit) begin
            res.rec.last = {{(EXACT_W-COUNT_W-1){1'b0}}, target};
          end
          res.off_count = target[COUNT_W] ? MAX_COUNT : target[COUNT_W-1:0];
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

endmodule

>>> design/pfdd_checker.sv
// Port-level checker for the PWM duty dither unit, bound to the top level.
// Depends on pfdd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "pwm_fractional_duty_dither_unit_assert.svh"

module pfdd_checker
  import pfdd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready
);

  `PFDD_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result beat changed while stalled")
  `PFDD_ASSERT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "second item taken while one is in flight")
  `PFDD_ASSERT(a_reg_align, clk, rst_n, out_tvalid |-> out_tdata[8:7] == 2'b10 && out_tdata[31:26] == 6'd0, "bad register address or pad bits")
  `PFDD_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_tvalid && in_tready, "not idle after reset")

endmodule

bind pwm_fractional_duty_dither_unit pfdd_checker u_pfdd_checker (.*);
